### sv/bpsp_pkg.sv
// Shared types, codes and width helpers for the breakpoint slot pool.
`timescale 1ns / 1ps

package bpsp_pkg;

  // Default sizing
  localparam int unsigned SLOTS_DEF      = 32;
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  // Field widths fixed by the interface
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ADDR_IN_W = 32;
  localparam int unsigned SLOT_NUM_W = 5;

  // Operation codes (code 3 is unused and ignored)
  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2
  } bpsp_op_e;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic sample;    // capture match flags for the item being accepted
    logic is_check;  // match on address rather than slot number
    logic alloc;     // append the new slot at the end of the active order
    logic remove;    // drop the matching slot and close the gap
    logic push;      // push a slot onto the free stack
    logic pop;       // pop the top of the free stack
  } bpsp_ctl_t;

  // Bits needed for a slot number
  function automatic int unsigned slot_w(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Bits needed for a count from 0 to n
  function automatic int unsigned cnt_w(input int unsigned n);
    return $clog2(n + 1);
  endfunction

endpackage

### sv/bpsp_cell.sv
// One cell of the slot pool: a free-stack entry and an active-order entry.
`timescale 1ns / 1ps

module bpsp_cell #(
  parameter int unsigned SLOTS      = bpsp_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_WIDTH = bpsp_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bpsp_pkg::bpsp_ctl_t                  ctl_i,
  input  logic [bpsp_pkg::cnt_w(SLOTS)-1:0]    act_cnt_i,
  input  logic [ADDR_WIDTH-1:0]                cmp_addr_i,
  input  logic [bpsp_pkg::SLOT_NUM_W-1:0]      cmp_num_i,
  input  logic [ADDR_WIDTH-1:0]                new_addr_i,
  input  logic [bpsp_pkg::slot_w(SLOTS)-1:0]   new_slot_i,
  // free stack neighbours: below is nearer the top
  input  logic [bpsp_pkg::slot_w(SLOTS)-1:0]   fs_above_i,
  input  logic [bpsp_pkg::slot_w(SLOTS)-1:0]   fs_below_i,
  output logic [bpsp_pkg::slot_w(SLOTS)-1:0]   fs_o,
  // active order neighbour one place more recent
  input  logic                                 nxt_vld_i,
  input  logic [bpsp_pkg::slot_w(SLOTS)-1:0]   nxt_slot_i,
  input  logic [ADDR_WIDTH-1:0]                nxt_addr_i,
  output logic                                 act_vld_o,
  output logic [bpsp_pkg::slot_w(SLOTS)-1:0]   act_slot_o,
  output logic [ADDR_WIDTH-1:0]                act_addr_o,
  // removal chain, from older cells upwards
  input  logic                                 rm_i,
  output logic                                 rm_o,
  // hit chain, from newer cells downwards
  input  logic                                 hit_i,
  input  logic [bpsp_pkg::slot_w(SLOTS)-1:0]   hit_slot_i,
  output logic                                 hit_o,
  output logic [bpsp_pkg::slot_w(SLOTS)-1:0]   hit_slot_o
);
  import bpsp_pkg::*;

  localparam int unsigned SW  = slot_w(SLOTS);
  localparam int unsigned CNW = cnt_w(SLOTS);
  localparam int unsigned CW  = (SW > SLOT_NUM_W) ? SW : SLOT_NUM_W;

  logic [SW-1:0]         fs_q, fs_d;
  logic                  vld_q, vld_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic                  mat_q, mat_d;
  logic                  here;
  logic                  shift;

  // Match flag, taken when the item is accepted
  always_comb begin
    mat_d = mat_q;
    if (ctl_i.sample) begin
      if (ctl_i.is_check) begin
        mat_d = vld_q && (addr_q == cmp_addr_i);
      end else begin
        mat_d = vld_q && (CW'(slot_q) == CW'(cmp_num_i));
      end
    end
  end

  // Free stack entry: pop pulls from above, push pushes from below
  always_comb begin
    fs_d = fs_q;
    if (ctl_i.pop) begin
      fs_d = fs_above_i;
    end else if (ctl_i.push) begin
      fs_d = fs_below_i;
    end
  end

  // Active entry: load on allocate, or close the gap on removal
  assign here  = ctl_i.alloc && (act_cnt_i == CNW'(IDX));
  assign shift = ctl_i.remove && (rm_i || mat_q);

  always_comb begin
    vld_d  = vld_q;
    slot_d = slot_q;
    addr_d = addr_q;
    if (here) begin
      vld_d  = 1'b1;
      slot_d = new_slot_i;
      addr_d = new_addr_i;
    end else if (shift) begin
      vld_d  = nxt_vld_i;
      slot_d = nxt_slot_i;
      addr_d = nxt_addr_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= SW'(IDX);
      vld_q <= 1'b0;
      mat_q <= 1'b0;
    end else begin
      fs_q  <= fs_d;
      vld_q <= vld_d;
      mat_q <= mat_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    addr_q <= addr_d;
  end

  // Chains
  assign rm_o       = rm_i || mat_q;
  assign hit_o      = hit_i || mat_q;
  assign hit_slot_o = hit_i ? hit_slot_i : (mat_q ? slot_q : '0);

  assign fs_o       = fs_q;
  assign act_vld_o  = vld_q;
  assign act_slot_o = slot_q;
  assign act_addr_o = addr_q;

endmodule

### sv/breakpoint_slot_pool_unit.sv
// Top level of the breakpoint slot pool: item stage, counters and the row of cells.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | opcode_i, address_i, slot_number_i
//   out     | output    | out_valid_o / out_stall_i  | success_o, result_slot_o
//
// On acceptance of an item every cell registers its match flag; when the item
// executes, the removal, hit and free-stack chains ripple through the
// row of cells, state updates and the result is registered.
// The item stage is held, with no state change, while the output register
// holds a result that is stalled; in_stall_o is high while an item is held.
// Reset is immediate: the free stack resets to 0 on top, no clearing pass.
`timescale 1ns / 1ps

module breakpoint_slot_pool_unit #(
  parameter int unsigned SLOTS      = bpsp_pkg::SLOTS_DEF,
  parameter int unsigned ADDR_WIDTH = bpsp_pkg::ADDR_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bpsp_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic [bpsp_pkg::ADDR_IN_W-1:0]    address_i,
  input  logic [bpsp_pkg::SLOT_NUM_W-1:0]   slot_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              success_o,
  output logic [bpsp_pkg::SLOT_NUM_W-1:0]   result_slot_o
);
  import bpsp_pkg::*;

  localparam int unsigned SW  = slot_w(SLOTS);
  localparam int unsigned CNW = cnt_w(SLOTS);

  // Item stage
  logic                  busy_q, busy_d;
  logic [OPCODE_W-1:0]   op_q;
  logic [SLOT_NUM_W-1:0] num_q;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [ADDR_WIDTH-1:0] addr_in;
  logic                  accept;
  logic                  exec;

  // Counters
  logic [CNW-1:0] free_cnt_q, free_cnt_d;
  logic [CNW-1:0] act_cnt_q, act_cnt_d;

  // Output register
  logic                  out_vld_q, out_vld_d;
  logic                  succ_q, succ_d;
  logic [SLOT_NUM_W-1:0] rslot_q, rslot_d;

  // Chains
  bpsp_ctl_t             ctl;
  logic [SW-1:0]         fs       [SLOTS];
  logic                  act_vld  [SLOTS];
  logic [SW-1:0]         act_slot [SLOTS];
  logic [ADDR_WIDTH-1:0] act_addr [SLOTS];
  logic                  rm       [SLOTS+1];
  logic                  hit      [SLOTS+1];
  logic [SW-1:0]         hit_slot [SLOTS+1];

  logic alloc_ok;
  logic found;

  assign addr_in = ADDR_WIDTH'(address_i);

  // Handshake
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign exec       = busy_q && (!out_vld_q || !out_stall_i);

  assign alloc_ok = (op_q == OP_ALLOC) && (free_cnt_q != '0);
  assign found    = rm[SLOTS];

  // Broadcast control
  always_comb begin
    ctl          = '0;
    ctl.sample   = accept;
    ctl.is_check = (opcode_i == OP_CHECK);
    ctl.alloc    = exec && alloc_ok;
    ctl.pop      = exec && alloc_ok;
    ctl.remove   = exec && (op_q == OP_FREE) && found;
    ctl.push     = exec && (op_q == OP_FREE) && found;
  end

  // Chain ends
  assign rm[0]           = 1'b0;
  assign hit[SLOTS]      = 1'b0;
  assign hit_slot[SLOTS] = '0;

  // Row of cells
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic [SW-1:0]         fs_above;
    logic [SW-1:0]         fs_below;
    logic                  nxt_vld;
    logic [SW-1:0]         nxt_slot;
    logic [ADDR_WIDTH-1:0] nxt_addr;

    if (k == 0) begin : g_bot
      assign fs_below = SW'(num_q);
    end else begin : g_mid_b
      assign fs_below = fs[k-1];
    end

    if (k == SLOTS - 1) begin : g_top
      assign fs_above = '0;
      assign nxt_vld  = 1'b0;
      assign nxt_slot = '0;
      assign nxt_addr = '0;
    end else begin : g_mid_t
      assign fs_above = fs[k+1];
      assign nxt_vld  = act_vld[k+1];
      assign nxt_slot = act_slot[k+1];
      assign nxt_addr = act_addr[k+1];
    end

    bpsp_cell #(
      .SLOTS      (SLOTS),
      .ADDR_WIDTH (ADDR_WIDTH),
      .IDX        (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .act_cnt_i  (act_cnt_q),
      .cmp_addr_i (addr_in),
      .cmp_num_i  (slot_number_i),
      .new_addr_i (addr_q),
      .new_slot_i (fs[0]),
      .fs_above_i (fs_above),
      .fs_below_i (fs_below),
      .fs_o       (fs[k]),
      .nxt_vld_i  (nxt_vld),
      .nxt_slot_i (nxt_slot),
      .nxt_addr_i (nxt_addr),
      .act_vld_o  (act_vld[k]),
      .act_slot_o (act_slot[k]),
      .act_addr_o (act_addr[k]),
      .rm_i       (rm[k]),
      .rm_o       (rm[k+1]),
      .hit_i      (hit[k+1]),
      .hit_slot_i (hit_slot[k+1]),
      .hit_o      (hit[k]),
      .hit_slot_o (hit_slot[k])
    );
  end

  // Item stage and counters
  always_comb begin
    busy_d     = busy_q;
    free_cnt_d = free_cnt_q;
    act_cnt_d  = act_cnt_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exec) begin
      busy_d = 1'b0;
    end
    if (ctl.alloc) begin
      free_cnt_d = free_cnt_q - 1'b1;
      act_cnt_d  = act_cnt_q + 1'b1;
    end else if (ctl.remove) begin
      free_cnt_d = free_cnt_q + 1'b1;
      act_cnt_d  = act_cnt_q - 1'b1;
    end
  end

  // Result selection and output register
  always_comb begin
    out_vld_d = out_vld_q;
    succ_d    = succ_q;
    rslot_d   = rslot_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (exec) begin
      out_vld_d = 1'b1;
      succ_d    = 1'b0;
      rslot_d   = '0;
      case (op_q)
        OP_ALLOC: begin
          succ_d  = alloc_ok;
          rslot_d = alloc_ok ? SLOT_NUM_W'(fs[0]) : '0;
        end
        OP_FREE: begin
          succ_d  = found;
          rslot_d = found ? num_q : '0;
        end
        OP_CHECK: begin
          succ_d  = hit[0];
          rslot_d = hit[0] ? SLOT_NUM_W'(hit_slot[0]) : '0;
        end
        default: begin
          succ_d  = 1'b0;
          rslot_d = '0;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      free_cnt_q <= CNW'(SLOTS);
      act_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      free_cnt_q <= free_cnt_d;
      act_cnt_q  <= act_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      num_q  <= slot_number_i;
      addr_q <= addr_in;
    end
    succ_q  <= succ_d;
    rslot_q <= rslot_d;
  end

  assign out_valid_o   = out_vld_q;
  assign success_o     = succ_q;
  assign result_slot_o = rslot_q;

  // Every slot is either free or active
  a_slot_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNW+1)'(free_cnt_q) + (CNW+1)'(act_cnt_q)) == (CNW+1)'(SLOTS))
    else $error("free and active counts do not add up to the pool size");

  // A new result only follows a held item
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(busy_q))
    else $error("result produced with no item held");

  // A successful allocate grows the active order by one
  a_alloc_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.alloc |=> (act_cnt_q == $past(act_cnt_q) + 1'b1))
    else $error("active count did not advance on allocate");

  // Removal and allocate never coincide
  a_one_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.alloc && ctl.remove))
    else $error("allocate and remove in the same cycle");

endmodule

### dv/testbench.sv
// Self-checking testbench for the breakpoint slot pool: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import bpsp_pkg::*;

  localparam int unsigned NUM_SLOTS = SLOTS_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS = 10;
  localparam int ADDR_POOL_N = 6;
  localparam int NUM_DIR = 23;

  typedef struct packed {
    logic                  success;
    logic [SLOT_NUM_W-1:0] slot;
  } pool_result_t;

  // One row of directed stimulus; reps > 1 steps the address by one per item
  typedef struct {
    logic [OPCODE_W-1:0]   op;
    logic [ADDR_IN_W-1:0]  addr;
    logic [SLOT_NUM_W-1:0] num;
    int                    reps;
    bit                    typed;
    logic                  success;
    logic [SLOT_NUM_W-1:0] slot;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OPCODE_W-1:0]   opcode_i;
  logic [ADDR_IN_W-1:0]  address_i;
  logic [SLOT_NUM_W-1:0] slot_number_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  success_o;
  logic [SLOT_NUM_W-1:0] result_slot_o;

  // Shadow copy of the pool
  logic [SLOT_NUM_W-1:0] free_slots[$];   // back is the top of the stack
  logic [SLOT_NUM_W-1:0] active_slots[$]; // oldest first
  logic [ADDR_IN_W-1:0]  slot_addr[NUM_SLOTS];

  pool_result_t pending_results[$];
  logic [ADDR_IN_W-1:0] addr_pool[ADDR_POOL_N];
  int src_idle_pct;
  int sink_idle_pct;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  dir_row_t dir_rows[NUM_DIR] = '{
    // empty pool: miss, free of an inactive slot, unused opcode
    '{OP_CHECK,  32'h0000_0000, 5'd0,  1, 1'b1, 1'b0, 5'd0},
    '{OP_FREE,   32'h0000_0000, 5'd0,  1, 1'b1, 1'b0, 5'd0},
    '{OP_UNUSED, 32'hffff_ffff, 5'd31, 1, 1'b1, 1'b0, 5'd0},
    // slots come off the stack from 0 upwards
    '{OP_ALLOC,  32'h0000_0000, 5'd0,  1, 1'b1, 1'b1, 5'd0},
    '{OP_ALLOC,  32'hffff_ffff, 5'd31, 1, 1'b1, 1'b1, 5'd1},
    '{OP_CHECK,  32'hffff_ffff, 5'd0,  1, 1'b1, 1'b1, 5'd1},
    '{OP_CHECK,  32'h0000_0000, 5'd0,  1, 1'b1, 1'b1, 5'd0},
    // duplicate address: most recent allocation wins
    '{OP_ALLOC,  32'hffff_ffff, 5'd0,  1, 1'b1, 1'b1, 5'd2},
    '{OP_CHECK,  32'hffff_ffff, 5'd0,  1, 1'b1, 1'b1, 5'd2},
    '{OP_FREE,   32'h0000_0000, 5'd2,  1, 1'b1, 1'b1, 5'd2},
    '{OP_CHECK,  32'hffff_ffff, 5'd0,  1, 1'b1, 1'b1, 5'd1},
    '{OP_CHECK,  32'h1234_5678, 5'd0,  1, 1'b1, 1'b0, 5'd0},
    '{OP_FREE,   32'h0000_0000, 5'd31, 1, 1'b1, 1'b0, 5'd0},
    '{OP_FREE,   32'h0000_0000, 5'd0,  1, 1'b1, 1'b1, 5'd0},
    // freed slots are reused last in, first out
    '{OP_ALLOC,  32'ha5a5_a5a5, 5'd0,  1, 1'b1, 1'b1, 5'd0},
    '{OP_ALLOC,  32'h8000_0000, 5'd0,  1, 1'b1, 1'b1, 5'd2},
    // fill the rest of the pool, then one too many
    '{OP_ALLOC,  32'h0000_1000, 5'd0, 29, 1'b0, 1'b0, 5'd0},
    '{OP_ALLOC,  32'h7fff_ffff, 5'd0,  1, 1'b1, 1'b0, 5'd0},
    '{OP_CHECK,  32'h0000_1010, 5'd0,  1, 1'b0, 1'b0, 5'd0},
    '{OP_FREE,   32'h0000_0000, 5'd31, 1, 1'b1, 1'b1, 5'd31},
    '{OP_ALLOC,  32'h5a5a_5a5a, 5'd0,  1, 1'b1, 1'b1, 5'd31},
    '{OP_CHECK,  32'h5a5a_5a5a, 5'd0,  1, 1'b1, 1'b1, 5'd31},
    '{OP_FREE,   32'h0000_0000, 5'd16, 1, 1'b0, 1'b0, 5'd0}
  };

  breakpoint_slot_pool_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .slot_number_i (slot_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .success_o     (success_o),
    .result_slot_o (result_slot_o)
  );

  always #5 clk_i = ~clk_i;

  // Pool state after reset: every slot free, slot 0 on top
  function automatic void reset_pool();
    free_slots.delete();
    active_slots.delete();
    for (int k = NUM_SLOTS - 1; k >= 0; k--) free_slots.push_back(k[SLOT_NUM_W-1:0]);
    foreach (slot_addr[k]) slot_addr[k] = '0;
  endfunction

  // Apply one item to the shadow pool and return the result it gives
  function automatic pool_result_t step_pool(input logic [OPCODE_W-1:0] op,
                                             input logic [ADDR_IN_W-1:0] addr,
                                             input logic [SLOT_NUM_W-1:0] num);
    pool_result_t res;
    int idx;
    res = '0;
    idx = -1;
    case (op)
      OP_ALLOC: begin
        if (free_slots.size() != 0) begin
          res.slot = free_slots.pop_back();
          slot_addr[res.slot] = addr;
          active_slots.push_back(res.slot);
          res.success = 1'b1;
        end
      end
      OP_FREE: begin
        foreach (active_slots[k]) if (active_slots[k] == num) idx = k;
        if (idx >= 0) begin
          active_slots.delete(idx);
          free_slots.push_back(num);
          res.success = 1'b1;
          res.slot = num;
        end
      end
      OP_CHECK: begin
        for (int k = active_slots.size() - 1; k >= 0 && !res.success; k--) begin
          if (slot_addr[active_slots[k]] == addr) begin
            res.success = 1'b1;
            res.slot = active_slots[k];
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Offer one item, wait for acceptance, then record what it should give
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_IN_W-1:0] addr,
                           input logic [SLOT_NUM_W-1:0] num, input bit typed,
                           input pool_result_t typed_res);
    pool_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    address_i     <= addr;
    slot_number_i <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = step_pool(op, addr, num);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Random item, mostly aimed at live slots and recurring addresses
  task automatic pick_item(input bit filling, output logic [OPCODE_W-1:0] op,
                           output logic [ADDR_IN_W-1:0] addr,
                           output logic [SLOT_NUM_W-1:0] num);
    int roll;
    int pick;
    roll = $urandom_range(99);
    pick = $urandom_range(3);
    addr = $urandom;
    num  = SLOT_NUM_W'($urandom_range(NUM_SLOTS - 1));
    if (roll < 4) begin
      op = OP_UNUSED;
    end else if (roll < (filling ? 60 : 25)) begin
      op = OP_ALLOC;
      if (pick != 0) addr = addr_pool[$urandom_range(ADDR_POOL_N - 1)];
    end else if (roll < (filling ? 84 : 49)) begin
      op = OP_CHECK;
      if (pick < 2 && active_slots.size() != 0)
        addr = slot_addr[active_slots[$urandom_range(active_slots.size() - 1)]];
      else if (pick == 2)
        addr = addr_pool[$urandom_range(ADDR_POOL_N - 1)];
    end else begin
      op = OP_FREE;
      if (pick != 0 && active_slots.size() != 0)
        num = active_slots[$urandom_range(active_slots.size() - 1)];
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < sink_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    pool_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d unexpected: success %0b slot %0d", results_seen, success_o,
                   result_slot_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (success_o !== exp_res.success || result_slot_o !== exp_res.slot) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected success %0b slot %0d, got success %0b slot %0d",
                     results_seen, exp_res.success, exp_res.slot, success_o, result_slot_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [OPCODE_W-1:0]   op;
    logic [ADDR_IN_W-1:0]  addr;
    logic [SLOT_NUM_W-1:0] num;
    pool_result_t          typed_res;
    bit                    filling;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    opcode_i      = '0;
    address_i     = '0;
    slot_number_i = '0;
    filling       = 1'b0;
    src_idle_pct  = 38;
    sink_idle_pct = 71;
    reset_pool();
    foreach (addr_pool[k]) addr_pool[k] = $urandom;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table
    foreach (dir_rows[r]) begin
      typed_res.success = dir_rows[r].success;
      typed_res.slot    = dir_rows[r].slot;
      for (int i = 0; i < dir_rows[r].reps; i++)
        send_item(dir_rows[r].op, dir_rows[r].addr + i, dir_rows[r].num, dir_rows[r].typed,
                  typed_res);
    end

    // Random traffic, alternating between filling and draining the pool
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        src_idle_pct  = 71;
        sink_idle_pct = 38;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (n % 60 == 0) filling = !filling;
      pick_item(filling, op, addr, num);
      send_item(op, addr, num, 1'b0, '0);
    end
    @(negedge clk_i) in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
